// File: rtl/srig_pkg.sv
`timescale 1ns / 1ps
// Shared widths and the controller-to-datapath command bundle.
package srig_pkg;

    localparam int C_W       = 32;
    localparam int IDX_W     = 16;
    localparam int IVL_W     = 16;
    localparam int DIV_CNT_W = $clog2(C_W);

    // item command codes
    localparam logic CMD_STEP = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    typedef struct packed {
        logic load;      // take a new ramp
        logic start;     // advance index, set up the division
        logic div_step;  // one quotient bit
        logic update;    // fold quotient into the interval
        logic push;      // move the result into the output register
    } t_dp_cmd;

endpackage

// File: rtl/srig_in_if.sv
`timescale 1ns / 1ps
// Input channel: command item with valid/ready handshake.
interface srig_in_if;
    logic                    valid;
    logic                    ready;
    logic                    command;
    logic [15:0]             start_interval;
    logic [15:0]             step_count;

    modport source (output valid, output command, output start_interval,
                    output step_count, input ready);
    modport sink   (input valid, input command, input start_interval,
                    input step_count, output ready);
endinterface

// File: rtl/srig_out_if.sv
`timescale 1ns / 1ps
// Output channel: interval item with valid/ready handshake.
interface srig_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] interval;

    modport source (output valid, output interval, input ready);
    modport sink   (input valid, input interval, output ready);
endinterface

// File: rtl/srig_datapath.sv
`timescale 1ns / 1ps
// Ramp state, bit-serial divider and output data register.
module srig_datapath
    import srig_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dp_cmd          i_cmd,
    input  logic [IVL_W-1:0] i_start_interval,
    input  logic [IDX_W-1:0] i_step_count,
    output logic [IVL_W-1:0] o_interval
);

    logic [C_W-1:0]   r_c,     n_c;
    logic [IDX_W-1:0] r_n,     n_n;
    logic [IDX_W-1:0] r_total, n_total;
    logic [IDX_W-1:0] r_half,  n_half;
    logic [C_W-1:0]   r_rem,   n_rem;
    logic [C_W-1:0]   r_quo,   n_quo;
    logic [C_W-1:0]   r_dsr,   n_dsr;
    logic             r_dec,   n_dec;
    logic             r_live,  n_live;
    logic [IVL_W-1:0] r_res,   n_res;
    logic [IVL_W-1:0] r_out,   n_out;

    logic [IDX_W-1:0] w_n_nx;
    logic [C_W-1:0]   w_inc;
    logic [C_W-1:0]   w_dif;
    logic [C_W:0]     w_rem_sh;
    logic [C_W:0]     w_rem_sub;
    logic [C_W-1:0]   w_c_upd;

    assign w_n_nx    = r_n + IDX_W'(1);
    assign w_inc     = C_W'(w_n_nx) + C_W'(1);
    assign w_dif     = C_W'(r_total) - C_W'(w_n_nx) + C_W'(2);
    assign w_rem_sh  = {r_rem, r_quo[C_W-1]};
    assign w_rem_sub = w_rem_sh - {1'b0, r_dsr};
    assign w_c_upd   = r_dec ? (r_c - r_quo) : (r_c + r_quo);

    always_comb begin
        n_c     = r_c;
        n_n     = r_n;
        n_total = r_total;
        n_half  = r_half;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_dsr   = r_dsr;
        n_dec   = r_dec;
        n_live  = r_live;
        n_res   = r_res;
        n_out   = r_out;
        if (i_cmd.load) begin
            n_c     = C_W'(i_start_interval);
            n_total = i_step_count;
            n_half  = i_step_count >> 1;
            n_n     = '0;
            n_res   = '0;
        end
        if (i_cmd.start) begin
            n_n    = w_n_nx;
            n_dec  = (w_n_nx < r_half);
            n_live = (w_n_nx < r_total);
            n_quo  = {r_c[C_W-2:0], 1'b0};
            n_rem  = '0;
            // shrink divisor 4(n+1), grow divisor 4(i-n+2)+1, both mod 2^32
            n_dsr  = (w_n_nx < r_half) ? {w_inc[C_W-3:0], 2'b00}
                                       : {w_dif[C_W-3:0], 2'b01};
        end
        if (i_cmd.div_step) begin
            if (!w_rem_sub[C_W]) begin
                n_rem = w_rem_sub[C_W-1:0];
                n_quo = {r_quo[C_W-2:0], 1'b1};
            end else begin
                n_rem = w_rem_sh[C_W-1:0];
                n_quo = {r_quo[C_W-2:0], 1'b0};
            end
        end
        if (i_cmd.update) begin
            n_c   = w_c_upd;
            n_res = r_live ? w_c_upd[IVL_W-1:0] : '0;
        end
        if (i_cmd.push) begin
            n_out = r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c     <= '0;
            r_n     <= '0;
            r_total <= '0;
            r_half  <= '0;
        end else begin
            r_c     <= n_c;
            r_n     <= n_n;
            r_total <= n_total;
            r_half  <= n_half;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_dsr  <= n_dsr;
        r_dec  <= n_dec;
        r_live <= n_live;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    assign o_interval = r_out;

endmodule

// File: rtl/srig_ctrl.sv
`timescale 1ns / 1ps
// Sequencer: accepts items, steps the divider, and owns output valid.
module srig_ctrl
    import srig_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_command,
    output logic    o_in_ready,
    input  logic    i_out_ready,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;
    localparam logic [1:0] S_PUSH = 2'd3;

    localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(C_W - 1);

    logic [1:0]           r_state, n_state;
    logic [DIV_CNT_W-1:0] r_cnt,   n_cnt;
    logic                 r_out_valid, n_out_valid;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (i_in_valid) begin
                    if (i_command == CMD_LOAD) begin
                        o_cmd.load = 1'b1;
                        n_state    = S_PUSH;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_state     = S_DIV;
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + DIV_CNT_W'(1);
                if (r_cnt == CNT_LAST) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_state      = S_PUSH;
            end
            S_PUSH: begin
                // hold until the output register is free or draining
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.push) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// File: rtl/stepper_ramp_interval_generator.sv
`timescale 1ns / 1ps
// A load item goes from idle straight to the push state; a step item goes
// through the bit-serial divider states, then the update and push states.
// No new item is taken until the last one is pushed; push waits while the
// output is stalled. A single 32-bit restoring divider is shared by both ramp segments.
// The output register lets the next item enter while a result waits.
// Synchronous active-low reset clears the ramp state and output valid.
module stepper_ramp_interval_generator
    import srig_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    srig_in_if.sink       i_in,
    srig_out_if.source    o_out
);

    t_dp_cmd w_cmd;
    logic    w_in_ready;
    logic    w_out_valid;

    srig_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_command   (i_in.command),
        .o_in_ready  (w_in_ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (w_out_valid),
        .o_cmd       (w_cmd)
    );

    srig_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_start_interval (i_in.start_interval),
        .i_step_count     (i_in.step_count),
        .o_interval       (o_out.interval)
    );

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;

endmodule

// File: rtl/srig_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the ramp interval generator, bound to the top level.
module srig_checker
    import srig_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_command,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_interval
);

    // reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // the block works on one item at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("ready right after an accepted item");

    // a step item still holds input ready low partway through its divider run
    a_step_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && (i_command == CMD_STEP)) |-> ##30 !i_in_ready)
        else $error("step finished before the divider could");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_interval)))
        else $error("stalled output item changed");

endmodule

bind stepper_ramp_interval_generator srig_checker u_srig_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_command   (i_in.command),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_interval  (o_out.interval)
);

// File: bench/tb_stepper_ramp_interval_generator.sv
`timescale 1ns / 1ps
// Self-checking testbench for stepper_ramp_interval_generator with a built-in ramp predictor.
module tb_stepper_ramp_interval_generator;
    import srig_pkg::*;

    localparam int   CYCLE_LIMIT = 200_000;
    localparam int   PHASE_ITEMS = 200;
    localparam int   TAIL_CYCLES = 40;

    typedef enum logic [1:0] {
        PH_STEADY,
        PH_SRC_GAPS,
        PH_SNK_STALLS,
        PH_BOTH
    } t_idle_phase;

    typedef struct {
        logic             cmd;
        logic [15:0]      start;
        logic [15:0]      count;
        t_idle_phase      phase;
        bit               drain;
    } t_ramp_item;

    logic i_clk;
    logic i_rst_n;

    srig_in_if  in_ch ();
    srig_out_if out_ch ();

    stepper_ramp_interval_generator DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // predictor state
    logic [C_W-1:0]   ramp_c;
    logic [IDX_W-1:0] ramp_n;
    logic [IDX_W-1:0] ramp_total;
    logic [IDX_W-1:0] ramp_half;

    t_ramp_item       pending_items[$];
    logic [IVL_W-1:0] expected_intervals[$];
    t_idle_phase      phase_now;

    int n_generated;
    int n_accepted;
    int n_loads;
    int n_steps;
    int n_wraps;
    int n_results;
    int n_live;
    int n_fail;
    int n_cycles;

    function automatic logic [IVL_W-1:0] predict_interval(input logic cmd,
                                                          input logic [15:0] start,
                                                          input logic [15:0] count);
        logic [C_W-1:0] twice;
        logic [C_W-1:0] divisor;
        logic [C_W-1:0] idx;
        if (cmd == CMD_LOAD) begin
            ramp_c     = C_W'(start);
            ramp_total = count;
            ramp_half  = count >> 1;
            ramp_n     = '0;
            n_loads++;
            return '0;
        end
        n_steps++;
        ramp_n = ramp_n + IDX_W'(1);
        if (ramp_n == '0)
            n_wraps++;
        idx   = C_W'(ramp_n);
        twice = ramp_c << 1;
        if (ramp_n < ramp_half) begin
            divisor = (idx + 32'd1) << 2;
            ramp_c  = ramp_c - twice / divisor;
        end else begin
            // distance to the end is signed; let it wrap in 32 bits
            divisor = ((C_W'(ramp_total) - idx + 32'd2) << 2) + 32'd1;
            ramp_c  = ramp_c + twice / divisor;
        end
        return (ramp_n < ramp_total) ? ramp_c[IVL_W-1:0] : '0;
    endfunction

    function automatic bit roll_idle(input t_idle_phase ph, input bit sink_side);
        int pct;
        case (ph)
            PH_STEADY:     pct = 0;
            PH_SRC_GAPS:   pct = sink_side ? 0 : 57;
            PH_SNK_STALLS: pct = sink_side ? 57 : 0;
            default:       pct = 7;
        endcase
        return $urandom_range(99) < pct;
    endfunction

    task automatic add_item(input logic cmd, input logic [15:0] start,
                            input logic [15:0] count, input t_idle_phase ph,
                            input bit drain);
        t_ramp_item it;
        it.cmd   = cmd;
        it.start = start;
        it.count = count;
        it.phase = ph;
        it.drain = drain;
        pending_items.push_back(it);
        n_generated++;
    endtask

    task automatic add_steps(input int num, input t_idle_phase ph);
        for (int k = 0; k < num; k++)
            add_item(CMD_STEP, 16'($urandom_range(65535)), 16'($urandom_range(65535)),
                     ph, 1'b0);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin : watchdog
        n_cycles = 0;
        while (n_cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            n_cycles++;
        end
        $error("timeout after %0d cycles, %0d of %0d items accepted",
               n_cycles, n_accepted, n_generated);
        $display("simulation failed");
        $finish;
    end

    // driver: predict on acceptance, then present the next item
    always @(posedge i_clk) begin : drive
        t_ramp_item       nxt;
        logic [IVL_W-1:0] want;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                want = predict_interval(in_ch.command, in_ch.start_interval,
                                        in_ch.step_count);
                expected_intervals.push_back(want);
                n_accepted++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (pending_items.size() != 0
                        && !(pending_items[0].drain && expected_intervals.size() != 0)
                        && !roll_idle(pending_items[0].phase, 1'b0)) begin
                    nxt = pending_items.pop_front();
                    phase_now            <= nxt.phase;
                    in_ch.valid          <= 1'b1;
                    in_ch.command        <= nxt.cmd;
                    in_ch.start_interval <= nxt.start;
                    in_ch.step_count     <= nxt.count;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each interval item with the oldest expectation
    always @(posedge i_clk) begin : observe
        logic [IVL_W-1:0] want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                n_results++;
                if (expected_intervals.size() == 0) begin
                    $error("interval: expected none, actual %0d", out_ch.interval);
                    n_fail++;
                end else begin
                    want = expected_intervals.pop_front();
                    if (out_ch.interval !== want) begin
                        $error("interval: expected %0d, actual %0d", want, out_ch.interval);
                        n_fail++;
                    end else if (want != '0) begin
                        n_live++;
                    end
                end
            end
            out_ch.ready <= !roll_idle(phase_now, 1'b1);
        end
    end

    initial begin : stimulus
        t_idle_phase ph;
        logic [15:0] start;
        logic [15:0] count;
        int          budget;
        int          lim;
        int          num;

        i_rst_n              = 1'b0;
        in_ch.valid          = 1'b0;
        in_ch.command        = CMD_STEP;
        in_ch.start_interval = '0;
        in_ch.step_count     = '0;
        out_ch.ready         = 1'b0;
        phase_now            = PH_STEADY;
        ramp_c               = '0;
        ramp_n               = '0;
        ramp_total           = '0;
        ramp_half            = '0;
        n_generated          = 0;
        n_accepted           = 0;
        n_loads              = 0;
        n_steps              = 0;
        n_wraps              = 0;
        n_results            = 0;
        n_live               = 0;
        n_fail               = 0;

        // steps on the reset state, all-ones and all-zeros in the ignored fields
        add_item(CMD_STEP, 16'hFFFF, 16'hFFFF, PH_STEADY, 1'b0);
        add_item(CMD_STEP, 16'h0000, 16'h0000, PH_STEADY, 1'b0);
        add_steps(1, PH_STEADY);
        // zero start interval stays zero
        add_item(CMD_LOAD, 16'd0, 16'd10, PH_STEADY, 1'b0);
        add_steps(3, PH_STEADY);
        // short ramp, then steps past its end
        add_item(CMD_LOAD, 16'hFFFF, 16'd4, PH_STEADY, 1'b0);
        add_steps(6, PH_STEADY);
        // zero and one step totals
        add_item(CMD_LOAD, 16'd1000, 16'd0, PH_STEADY, 1'b0);
        add_steps(1, PH_STEADY);
        add_item(CMD_LOAD, 16'd5000, 16'd1, PH_STEADY, 1'b0);
        add_steps(2, PH_STEADY);
        add_item(CMD_LOAD, 16'hFFFF, 16'hFFFF, PH_STEADY, 1'b0);
        add_steps(3, PH_STEADY);

        // start of a full-length ramp, after the block drains
        add_item(CMD_LOAD, 16'($urandom_range(65535)), 16'hFFFF, PH_STEADY, 1'b1);
        add_steps(40, PH_STEADY);

        for (int p = 0; p < 4; p++) begin
            ph     = t_idle_phase'(p);
            budget = PHASE_ITEMS;
            while (budget > 0) begin
                case ($urandom_range(9))
                    0:       start = 16'd0;
                    1:       start = 16'hFFFF;
                    default: start = 16'($urandom_range(65535));
                endcase
                case ($urandom_range(9))
                    0:       count = 16'd0;
                    1:       count = 16'($urandom_range(65535));
                    2:       count = 16'hFFFF;
                    default: count = 16'($urandom_range(48, 1));
                endcase
                // hold the sender at each phase start until the block drains
                add_item(CMD_LOAD, start, count, ph, budget == PHASE_ITEMS);
                lim = ((count > 60) ? 60 : int'(count)) + $urandom_range(3);
                // some ramps get cut short by the next load
                num = ($urandom_range(4) == 0) ? $urandom_range(lim) : lim;
                add_steps(num, ph);
                budget -= 1 + num;
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted != n_generated)
            @(posedge i_clk);
        while (expected_intervals.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Ran %0d loads and %0d steps (%0d index wraps) under four idle patterns.",
                 n_loads, n_steps, n_wraps);
        $display("Checked %0d interval items, %0d of them nonzero, in %0d cycles.",
                 n_results, n_live, n_cycles);
        if (n_fail == 0 && expected_intervals.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/srig_pkg.sv
rtl/srig_in_if.sv
rtl/srig_out_if.sv
rtl/srig_datapath.sv
rtl/srig_ctrl.sv
rtl/stepper_ramp_interval_generator.sv
rtl/srig_checker.sv
bench/tb_stepper_ramp_interval_generator.sv
